// ----- rtl/core/bts_pkg.sv -----
// Shared types and constants for the bilinear texture sampler core.
// Holds command codes, configuration register indexes and controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps

package bts_pkg;

    // Default sizes, handed to the top level as parameter defaults
    localparam int DEF_MAX_TEXELS = 65536;
    localparam int DEF_MAX_DIM    = 256;

    // Full-scale channel in Q8.8 byte units
    localparam logic [15:0] FULL_Q88 = 16'hFF00;

    // Configuration register indexes
    localparam logic [1:0] CFG_TEX_WIDTH     = 2'd0;
    localparam logic [1:0] CFG_TEX_HEIGHT    = 2'd1;
    localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd2;

    // Item commands
    typedef enum logic [1:0] {
        CMD_WRITE    = 2'd0,
        CMD_PIXEL    = 2'd1,
        CMD_NEAREST  = 2'd2,
        CMD_BILINEAR = 2'd3
    } t_cmd;

    // Result source select
    typedef enum logic [1:0] {
        OSEL_WHITE = 2'd0,
        OSEL_TEXEL = 2'd1,
        OSEL_MIX   = 2'd2
    } t_out_sel;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_FETCH,
        ST_DRAIN,
        ST_MIX_X,
        ST_MIX_Y,
        ST_OUT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic     write;      // store texel from the input ports
        logic     latch;      // capture coordinates of an accepted item
        logic     scale;      // clamp and scale coordinates
        logic     scale_pix;  // scale step uses pixel coordinates
        logic     fetch;      // issue one texel read
        logic [1:0] fetch_sel; // bit0 picks x1, bit1 picks y1
        logic     mix_x;      // interpolate along x
        logic     mix_y;      // interpolate along y
        logic     out_load;   // load result registers and strobe
        t_out_sel out_sel;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic empty;          // texture has no width, height or channels
    } t_dp_status;

endpackage

// ----- rtl/core/bts_ctrl.sv -----
// Sequencing controller for the bilinear texture sampler.
// Walks scale, fetch, interpolate and output steps. Depends on bts_pkg.
`timescale 1ns / 1ps

module bts_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [1:0]            i_cmd,
    input  bts_pkg::t_dp_status   i_status,
    output logic                  o_busy,
    output bts_pkg::t_dp_cmd      o_dp_cmd
);

    localparam logic [1:0] FETCH_LAST = 2'd3;

    bts_pkg::t_state r_state, n_state;
    bts_pkg::t_cmd   r_cmd, n_cmd;
    logic [1:0]      r_fcnt, n_fcnt;
    logic            accept;
    logic            is_bilinear;

    assign accept      = i_start && (r_state == bts_pkg::ST_IDLE);
    assign is_bilinear = (r_cmd == bts_pkg::CMD_BILINEAR);
    assign o_busy      = (r_state != bts_pkg::ST_IDLE);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bts_pkg::ST_IDLE;
            r_cmd   <= bts_pkg::CMD_WRITE;
            r_fcnt  <= '0;
        end else begin
            r_state <= n_state;
            r_cmd   <= n_cmd;
            r_fcnt  <= n_fcnt;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_fcnt   = r_fcnt;
        o_dp_cmd = '0;
        o_dp_cmd.out_sel = bts_pkg::OSEL_WHITE;
        o_dp_cmd.fetch_sel = r_fcnt;
        o_dp_cmd.scale_pix = (r_cmd == bts_pkg::CMD_PIXEL);

        unique case (r_state)
            bts_pkg::ST_IDLE: begin
                if (accept) begin
                    o_dp_cmd.latch = 1'b1;
                    n_cmd = bts_pkg::t_cmd'(i_cmd);
                    if (bts_pkg::t_cmd'(i_cmd) == bts_pkg::CMD_WRITE) begin
                        // store in the accept cycle, no result
                        o_dp_cmd.write = 1'b1;
                    end else if (i_status.empty) begin
                        n_state = bts_pkg::ST_OUT;
                    end else begin
                        n_state = bts_pkg::ST_SCALE;
                    end
                end
            end
            bts_pkg::ST_SCALE: begin
                o_dp_cmd.scale = 1'b1;
                n_fcnt  = '0;
                n_state = bts_pkg::ST_FETCH;
            end
            bts_pkg::ST_FETCH: begin
                o_dp_cmd.fetch = 1'b1;
                if (is_bilinear && (r_fcnt != FETCH_LAST)) begin
                    n_fcnt = r_fcnt + 2'd1;
                end else begin
                    n_state = bts_pkg::ST_DRAIN;
                end
            end
            bts_pkg::ST_DRAIN: begin
                n_state = is_bilinear ? bts_pkg::ST_MIX_X : bts_pkg::ST_OUT;
            end
            bts_pkg::ST_MIX_X: begin
                o_dp_cmd.mix_x = 1'b1;
                n_state = bts_pkg::ST_MIX_Y;
            end
            bts_pkg::ST_MIX_Y: begin
                o_dp_cmd.mix_y = 1'b1;
                n_state = bts_pkg::ST_OUT;
            end
            bts_pkg::ST_OUT: begin
                o_dp_cmd.out_load = 1'b1;
                if (i_status.empty) begin
                    o_dp_cmd.out_sel = bts_pkg::OSEL_WHITE;
                end else if (is_bilinear) begin
                    o_dp_cmd.out_sel = bts_pkg::OSEL_MIX;
                end else begin
                    o_dp_cmd.out_sel = bts_pkg::OSEL_TEXEL;
                end
                n_state = bts_pkg::ST_IDLE;
            end
            default: begin
                n_state = bts_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/bts_datapath.sv -----
// Datapath of the bilinear texture sampler: config registers, texel memory,
// coordinate scaling, address generation and two-pass interpolation. Depends on bts_pkg.
`timescale 1ns / 1ps

module bts_datapath #(
    parameter int MAX_TEXELS = bts_pkg::DEF_MAX_TEXELS,
    parameter int MAX_DIM    = bts_pkg::DEF_MAX_DIM
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [8:0]           i_cfg_data,
    input  bts_pkg::t_dp_cmd     i_dp_cmd,
    output bts_pkg::t_dp_status  o_status,
    input  logic [15:0]          i_texel_index,
    input  logic [7:0]           i_byte_red,
    input  logic [7:0]           i_byte_green,
    input  logic [7:0]           i_byte_blue,
    input  logic [7:0]           i_byte_alpha,
    input  logic signed [15:0]   i_pixel_x,
    input  logic signed [15:0]   i_pixel_y,
    input  logic signed [17:0]   i_coord_u,
    input  logic signed [17:0]   i_coord_v,
    output logic                 o_valid,
    output logic [15:0]          o_out_red,
    output logic [15:0]          o_out_green,
    output logic [15:0]          o_out_blue,
    output logic [15:0]          o_out_alpha
);

    localparam int DW  = $clog2(MAX_DIM + 1);                        // dimension width
    localparam int PXW = DW + 16;                                    // scaled coord, Q.16
    localparam int LW  = 2 * DW + 1;                                 // linear address
    localparam int AW  = (MAX_TEXELS > 1) ? $clog2(MAX_TEXELS) : 1; // memory address
    localparam logic [16:0] UV_ONE  = 17'h10000;
    localparam logic [47:0] HALF_LSB = 48'h0000_8000_0000;

    // Configuration registers
    logic [8:0] r_tex_width;
    logic [8:0] r_tex_height;
    logic [2:0] r_chan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_width  <= '0;
            r_tex_height <= '0;
            r_chan       <= 3'd4;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bts_pkg::CFG_TEX_WIDTH:     r_tex_width  <= i_cfg_data;
                bts_pkg::CFG_TEX_HEIGHT:    r_tex_height <= i_cfg_data;
                bts_pkg::CFG_CHANNEL_COUNT: r_chan       <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Effective dimensions, capped at MAX_DIM
    logic [DW-1:0] w, h;
    assign w = (32'(r_tex_width) > 32'(MAX_DIM))  ? DW'(MAX_DIM) : DW'(r_tex_width);
    assign h = (32'(r_tex_height) > 32'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(r_tex_height);
    assign o_status.empty = (w == '0) || (h == '0) || (r_chan == '0);

    // Item coordinate latch
    logic signed [15:0] r_pix_x, r_pix_y;
    logic signed [17:0] r_u, r_v;

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.latch) begin
            r_pix_x <= i_pixel_x;
            r_pix_y <= i_pixel_y;
            r_u     <= i_coord_u;
            r_v     <= i_coord_v;
        end
    end

    // Clamp and scale: pixel clamp to the texture, or uv clamp to 0..1 times (size-1)
    logic [16:0]    uc, vc;
    logic [DW-1:0]  xc, yc;
    logic [DW+16:0] prod_x, prod_y;
    logic [PXW-1:0] r_px, r_py;

    always_comb begin
        if (r_u[17])                       uc = '0;
        else if (r_u[16:0] > UV_ONE)       uc = UV_ONE;
        else                               uc = r_u[16:0];
        if (r_v[17])                       vc = '0;
        else if (r_v[16:0] > UV_ONE)       vc = UV_ONE;
        else                               vc = r_v[16:0];

        if (r_pix_x[15])                   xc = '0;
        else if (r_pix_x >= 16'(w))        xc = w - DW'(1);
        else                               xc = DW'(r_pix_x);
        if (r_pix_y[15])                   yc = '0;
        else if (r_pix_y >= 16'(h))        yc = h - DW'(1);
        else                               yc = DW'(r_pix_y);

        prod_x = (DW+17)'(uc) * (DW+17)'(w - DW'(1));
        prod_y = (DW+17)'(vc) * (DW+17)'(h - DW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.scale) begin
            if (i_dp_cmd.scale_pix) begin
                r_px <= {xc, 16'h0000};
                r_py <= {yc, 16'h0000};
            end else begin
                r_px <= prod_x[PXW-1:0];
                r_py <= prod_y[PXW-1:0];
            end
        end
    end

    // Neighbor coordinates and linear address
    logic [DW-1:0] x0, y0, x1, y1, xs, ys;
    logic [15:0]   fx, fy;
    logic [LW-1:0] lin;
    logic          addr_ok;

    always_comb begin
        x0 = r_px[PXW-1:16];
        y0 = r_py[PXW-1:16];
        fx = r_px[15:0];
        fy = r_py[15:0];
        x1 = (x0 == w - DW'(1)) ? x0 : x0 + DW'(1);
        y1 = (y0 == h - DW'(1)) ? y0 : y0 + DW'(1);
        xs = i_dp_cmd.fetch_sel[0] ? x1 : x0;
        ys = i_dp_cmd.fetch_sel[1] ? y1 : y0;
        lin = LW'(ys) * LW'(w) + LW'(xs);
        addr_ok = (32'(lin) < 32'(MAX_TEXELS));
    end

    // Single-port texel memory: writes at accept, reads while fetching
    logic [31:0]   mem [MAX_TEXELS];
    logic [31:0]   r_rdata;
    logic          wr_en;
    logic [AW-1:0] mem_addr;

    assign wr_en    = i_dp_cmd.write && (32'(i_texel_index) < 32'(MAX_TEXELS));
    assign mem_addr = wr_en ? AW'(i_texel_index) : AW'(lin);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[mem_addr] <= {i_byte_alpha, i_byte_blue, i_byte_green, i_byte_red};
        end
        r_rdata <= mem[mem_addr];
    end

    // Read tag is registered alongside the memory read data
    logic       r_rd_vld;
    logic       r_rd_ok;
    logic [1:0] r_rd_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_dp_cmd.fetch;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ok  <= addr_ok;
        r_rd_tag <= i_dp_cmd.fetch_sel;
    end

    // Channel decode: out-of-store reads zero bytes, missing channels read full
    logic [15:0] chan_q [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (3'(k) < r_chan) begin
                chan_q[k] = r_rd_ok ? {r_rdata[8*k +: 8], 8'h00} : 16'h0000;
            end else begin
                chan_q[k] = bts_pkg::FULL_Q88;
            end
        end
    end

    // Neighbor texels: 0 (x0,y0), 1 (x1,y0), 2 (x0,y1), 3 (x1,y1)
    logic [15:0] r_tex [4][4];

    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            for (int k = 0; k < 4; k++) begin
                r_tex[r_rd_tag][k] <= chan_q[k];
            end
        end
    end

    // a*(65536-f) + b*f computed as a*65536 + (b-a)*f
    function automatic logic [31:0] f_lerp_x(input logic [15:0] a, input logic [15:0] b,
                                             input logic [15:0] f);
        logic signed [16:0] d;
        logic signed [33:0] p;
        logic signed [34:0] s;
        d = $signed({1'b0, b}) - $signed({1'b0, a});
        p = d * $signed({1'b0, f});
        s = $signed({3'b000, a, 16'h0000}) + $signed({p[33], p});
        return s[31:0];
    endfunction

    function automatic logic [47:0] f_lerp_y(input logic [31:0] a, input logic [31:0] b,
                                             input logic [15:0] f);
        logic signed [32:0] d;
        logic signed [49:0] p;
        logic signed [50:0] s;
        d = $signed({1'b0, b}) - $signed({1'b0, a});
        p = d * $signed({1'b0, f});
        s = $signed({3'b000, a, 16'h0000}) + $signed({p[49], p});
        return s[47:0];
    endfunction

    // Interpolation along x, then along y, one lane per channel
    logic [31:0] r_row0 [4];
    logic [31:0] r_row1 [4];
    logic [47:0] r_mix  [4];

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.mix_x) begin
            for (int k = 0; k < 4; k++) begin
                r_row0[k] <= f_lerp_x(r_tex[0][k], r_tex[1][k], fx);
                r_row1[k] <= f_lerp_x(r_tex[2][k], r_tex[3][k], fx);
            end
        end
        if (i_dp_cmd.mix_y) begin
            for (int k = 0; k < 4; k++) begin
                r_mix[k] <= f_lerp_y(r_row0[k], r_row1[k], fy);
            end
        end
    end

    // Result select and round half up on the 2^32 scale
    logic [47:0] round_sum [4];
    logic [15:0] res [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            round_sum[k] = r_mix[k] + HALF_LSB;
            unique case (i_dp_cmd.out_sel)
                bts_pkg::OSEL_WHITE: res[k] = bts_pkg::FULL_Q88;
                bts_pkg::OSEL_TEXEL: res[k] = r_tex[0][k];
                bts_pkg::OSEL_MIX:   res[k] = round_sum[k][47:32];
                default:             res[k] = bts_pkg::FULL_Q88;
            endcase
        end
    end

    // Result registers, one-cycle strobe
    logic        r_valid;
    logic [15:0] r_out [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_dp_cmd.out_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.out_load) begin
            for (int k = 0; k < 4; k++) begin
                r_out[k] <= res[k];
            end
        end
    end

    assign o_valid     = r_valid;
    assign o_out_red   = r_out[0];
    assign o_out_green = r_out[1];
    assign o_out_blue  = r_out[2];
    assign o_out_alpha = r_out[3];

endmodule

// ----- rtl/core/bilinear_texture_sampler_core.sv -----
// Bilinear items step through scale, four fetches, drain, x mix, y mix and output before the
// result strobe; pixel fetch and nearest through scale, one fetch, drain and output; an empty
// texture goes straight to output. A texel write takes the accept cycle and returns no result.
// A new item is taken in the strobe cycle but not while busy; the texel memory is single-port.
// Reset (synchronous, active low) clears control, sets width 0, height 0, four channels;
// the texel store is not cleared. Results are strobed for one cycle and cannot be stalled.
`timescale 1ns / 1ps

module bilinear_texture_sampler_core #(
    parameter int MAX_TEXELS = bts_pkg::DEF_MAX_TEXELS,
    parameter int MAX_DIM    = bts_pkg::DEF_MAX_DIM
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration write port
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [8:0]          i_cfg_data,
    // Item command
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_cmd,
    input  logic [15:0]         i_texel_index,
    input  logic [7:0]          i_byte_red,
    input  logic [7:0]          i_byte_green,
    input  logic [7:0]          i_byte_blue,
    input  logic [7:0]          i_byte_alpha,
    input  logic signed [15:0]  i_pixel_x,
    input  logic signed [15:0]  i_pixel_y,
    input  logic signed [17:0]  i_coord_u,
    input  logic signed [17:0]  i_coord_v,
    // Result
    output logic                o_valid,
    output logic [15:0]         o_out_red,
    output logic [15:0]         o_out_green,
    output logic [15:0]         o_out_blue,
    output logic [15:0]         o_out_alpha
);

    bts_pkg::t_dp_cmd    dp_cmd;
    bts_pkg::t_dp_status dp_status;

    // Sequencer
    bts_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_cmd    (i_cmd),
        .i_status (dp_status),
        .o_busy   (busy),
        .o_dp_cmd (dp_cmd)
    );

    // Datapath and texel store
    bts_datapath #(
        .MAX_TEXELS (MAX_TEXELS),
        .MAX_DIM    (MAX_DIM)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_dp_cmd      (dp_cmd),
        .o_status      (dp_status),
        .i_texel_index (i_texel_index),
        .i_byte_red    (i_byte_red),
        .i_byte_green  (i_byte_green),
        .i_byte_blue   (i_byte_blue),
        .i_byte_alpha  (i_byte_alpha),
        .i_pixel_x     (i_pixel_x),
        .i_pixel_y     (i_pixel_y),
        .i_coord_u     (i_coord_u),
        .i_coord_v     (i_coord_v),
        .o_valid       (o_valid),
        .o_out_red     (o_out_red),
        .o_out_green   (o_out_green),
        .o_out_blue    (o_out_blue),
        .o_out_alpha   (o_out_alpha)
    );

    // A result only follows a busy cycle
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without a preceding busy cycle");

    // Strobes never come back to back
    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    // A texel write completes in its accept cycle
    a_write_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cmd == bts_pkg::CMD_WRITE)) |=> !busy)
        else $error("texel write left the block busy");

    // Memory port is never asked to write and read in one cycle
    a_port_conflict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(dp_cmd.write && dp_cmd.fetch))
        else $error("texel write and fetch on the same cycle");

endmodule

// ----- tb/bts_sample_checker.sv -----
// Checker for the bilinear texture sampler core: tracks configuration and texel writes,
// predicts each sampled color and compares it with the strobed result.
// Depends on bts_pkg.
`timescale 1ns / 1ps

module bts_sample_checker
    import bts_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [8:0]         i_cfg_data,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic [1:0]         i_cmd,
    input  logic [15:0]        i_texel_index,
    input  logic [7:0]         i_byte_red,
    input  logic [7:0]         i_byte_green,
    input  logic [7:0]         i_byte_blue,
    input  logic [7:0]         i_byte_alpha,
    input  logic signed [15:0] i_pixel_x,
    input  logic signed [15:0] i_pixel_y,
    input  logic signed [17:0] i_coord_u,
    input  logic signed [17:0] i_coord_v,
    input  logic               i_valid,
    input  logic [15:0]        i_out_red,
    input  logic [15:0]        i_out_green,
    input  logic [15:0]        i_out_blue,
    input  logic [15:0]        i_out_alpha,
    output int                 o_fail_count,
    output int                 o_pending
);

    // Four Q8.8 channels, index 0 is red
    typedef logic [3:0][15:0] quad_t;

    logic [31:0] texel_mem [0:65535];
    logic [8:0]  width_reg;
    logic [8:0]  height_reg;
    logic [2:0]  chan_reg;
    quad_t       expected_colors[$];
    int          fail_total = 0;
    string       chan_name [4] = '{"red", "green", "blue", "alpha"};

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string msg);
        fail_total++;
        $display("%0t bts_sample_checker: %s", $time, msg);
    endtask

    // Sizes above 256 act as 256
    function automatic int unsigned clip_dim(input logic [8:0] d);
        return (d > 9'd256) ? 256 : int'(d);
    endfunction

    function automatic int unsigned live_channels();
        return (chan_reg > 3'd4) ? 4 : int'(chan_reg);
    endfunction

    // One texel as Q8.8; channels past the count read full
    function automatic quad_t read_texel(input int unsigned x, input int unsigned y,
                                         input int unsigned w);
        longint unsigned addr;
        logic [31:0]     word;
        quad_t           c;
        addr = longint'(y) * w + x;
        word = (addr < 65536) ? texel_mem[addr[15:0]] : 32'd0;
        for (int k = 0; k < 4; k++)
            c[k] = (k < live_channels()) ? {word[8*k +: 8], 8'h00} : FULL_Q88;
        return c;
    endfunction

    function automatic int unsigned clamp_pixel(input logic signed [15:0] p,
                                                input int unsigned size);
        int sp;
        sp = int'(p);
        if (sp < 0)
            return 0;
        if (sp > int'(size) - 1)
            return size - 1;
        return sp;
    endfunction

    // Clamp Q2.16 to 0..1 and scale by size-1, result in Q.16
    function automatic longint unsigned scale_coord(input logic signed [17:0] c,
                                                    input int unsigned size);
        longint cu;
        cu = longint'(c);
        if (cu < 0)
            cu = 0;
        if (cu > 65536)
            cu = 65536;
        return longint'(cu) * (size - 1);
    endfunction

    function automatic quad_t predict_sample(input t_cmd cmd,
                                             input logic signed [15:0] px,
                                             input logic signed [15:0] py,
                                             input logic signed [17:0] u,
                                             input logic signed [17:0] v);
        int unsigned     w, h, x0, y0, x1, y1;
        longint unsigned sx, sy, fx, fy, r0, r1, mix;
        quad_t           t00, t10, t01, t11, res;
        w = clip_dim(width_reg);
        h = clip_dim(height_reg);
        if (w == 0 || h == 0 || live_channels() == 0)
            return {4{FULL_Q88}};
        if (cmd == CMD_PIXEL)
            return read_texel(clamp_pixel(px, w), clamp_pixel(py, h), w);
        sx = scale_coord(u, w);
        sy = scale_coord(v, h);
        x0 = 32'(sx >> 16);
        y0 = 32'(sy >> 16);
        if (cmd == CMD_NEAREST)
            return read_texel(x0, y0, w);
        fx = sx & 64'hFFFF;
        fy = sy & 64'hFFFF;
        x1 = (x0 + 1 > w - 1) ? w - 1 : x0 + 1;
        y1 = (y0 + 1 > h - 1) ? h - 1 : y0 + 1;
        t00 = read_texel(x0, y0, w);
        t10 = read_texel(x1, y0, w);
        t01 = read_texel(x0, y1, w);
        t11 = read_texel(x1, y1, w);
        // exact row mixes, exact column mix, one round-half-up at the end
        for (int k = 0; k < 4; k++) begin
            r0 = longint'(t00[k]) * (65536 - fx) + longint'(t10[k]) * fx;
            r1 = longint'(t01[k]) * (65536 - fx) + longint'(t11[k]) * fx;
            mix = r0 * (65536 - fy) + r1 * fy;
            res[k] = 16'((mix + 64'h8000_0000) >> 32);
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        quad_t got, want;
        if (!i_rst_n) begin
            width_reg  = '0;
            height_reg = '0;
            chan_reg   = 3'd4;
            expected_colors.delete();
        end else begin
            // result strobe: compare with the oldest expectation
            if (i_valid) begin
                got = {i_out_alpha, i_out_blue, i_out_green, i_out_red};
                if (expected_colors.size() == 0) begin
                    report_mismatch("result strobed with no item outstanding");
                end else begin
                    want = expected_colors.pop_front();
                    for (int k = 0; k < 4; k++)
                        if (got[k] !== want[k])
                            report_mismatch($sformatf("%s got %h want %h",
                                                      chan_name[k], got[k], want[k]));
                end
            end
            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TEX_WIDTH:     width_reg  = i_cfg_data;
                    CFG_TEX_HEIGHT:    height_reg = i_cfg_data;
                    CFG_CHANNEL_COUNT: chan_reg   = i_cfg_data[2:0];
                    default: ;
                endcase
            end
            // accepted item
            if (i_start && !i_busy) begin
                if (t_cmd'(i_cmd) == CMD_WRITE)
                    texel_mem[i_texel_index] = {i_byte_alpha, i_byte_blue,
                                                i_byte_green, i_byte_red};
                else
                    expected_colors.push_back(predict_sample(t_cmd'(i_cmd),
                                                             i_pixel_x, i_pixel_y,
                                                             i_coord_u, i_coord_v));
            end
        end
        o_pending    <= expected_colors.size();
        o_fail_count <= fail_total;
    end

endmodule

// ----- tb/bilinear_texture_sampler_core_tb.sv -----
// Testbench top for the bilinear texture sampler core: clock, reset, configuration
// phases and item stimulus; checking is done by bts_sample_checker.
// Depends on bts_pkg, bilinear_texture_sampler_core and bts_sample_checker.
`timescale 1ns / 1ps

module bilinear_texture_sampler_core_tb;
    import bts_pkg::*;

    localparam logic [1:0] CFG_SPARE = 2'd3;   // unmapped register index
    localparam int SETTLE_CYCLES  = 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 13;
    localparam int PHASE_ITEMS    = 16;

    typedef struct packed {
        t_cmd               cmd;
        logic [15:0]        texel_index;
        logic [31:0]        texel;      // alpha, blue, green, red
        logic signed [15:0] pixel_x;
        logic signed [15:0] pixel_y;
        logic signed [17:0] coord_u;
        logic signed [17:0] coord_v;
    } tex_req_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = '0;
    logic [8:0]         cfg_data = '0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         cmd = '0;
    logic [15:0]        texel_index = '0;
    logic [7:0]         byte_red = '0;
    logic [7:0]         byte_green = '0;
    logic [7:0]         byte_blue = '0;
    logic [7:0]         byte_alpha = '0;
    logic signed [15:0] pixel_x = '0;
    logic signed [15:0] pixel_y = '0;
    logic signed [17:0] coord_u = '0;
    logic signed [17:0] coord_v = '0;
    logic               o_valid;
    logic [15:0]        out_red, out_green, out_blue, out_alpha;
    int                 err_count;
    int                 pending;
    int                 idle_cycles = 0;
    int unsigned        tex_w = 0;
    int unsigned        tex_h = 0;
    int unsigned        filled = 0;
    bit                 gaps_on = 1'b1;

    always #4 clk = ~clk;

    bilinear_texture_sampler_core i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .start         (start),
        .busy          (busy),
        .i_cmd         (cmd),
        .i_texel_index (texel_index),
        .i_byte_red    (byte_red),
        .i_byte_green  (byte_green),
        .i_byte_blue   (byte_blue),
        .i_byte_alpha  (byte_alpha),
        .i_pixel_x     (pixel_x),
        .i_pixel_y     (pixel_y),
        .i_coord_u     (coord_u),
        .i_coord_v     (coord_v),
        .o_valid       (o_valid),
        .o_out_red     (out_red),
        .o_out_green   (out_green),
        .o_out_blue    (out_blue),
        .o_out_alpha   (out_alpha)
    );

    bts_sample_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_start       (start),
        .i_busy        (busy),
        .i_cmd         (cmd),
        .i_texel_index (texel_index),
        .i_byte_red    (byte_red),
        .i_byte_green  (byte_green),
        .i_byte_blue   (byte_blue),
        .i_byte_alpha  (byte_alpha),
        .i_pixel_x     (pixel_x),
        .i_pixel_y     (pixel_y),
        .i_coord_u     (coord_u),
        .i_coord_v     (coord_v),
        .i_valid       (o_valid),
        .i_out_red     (out_red),
        .i_out_green   (out_green),
        .i_out_blue    (out_blue),
        .i_out_alpha   (out_alpha),
        .o_fail_count  (err_count),
        .o_pending     (pending)
    );

    // Watchdog: too long without an accepted item or a result
    always @(posedge clk) begin
        if ((start && !busy) || o_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("bilinear_texture_sampler_core_tb: errors");
            $finish;
        end
    end

    // Item builders; fields the command ignores carry random values
    function automatic tex_req_t noise_req();
        tex_req_t r;
        r.cmd         = t_cmd'($urandom_range(0, 3));
        r.texel_index = 16'($urandom);
        r.texel       = $urandom;
        r.pixel_x     = 16'($urandom);
        r.pixel_y     = 16'($urandom);
        r.coord_u     = 18'($urandom);
        r.coord_v     = 18'($urandom);
        return r;
    endfunction

    function automatic tex_req_t write_item(input logic [15:0] idx, input logic [31:0] word);
        tex_req_t r;
        r = noise_req();
        r.cmd         = CMD_WRITE;
        r.texel_index = idx;
        r.texel       = word;
        return r;
    endfunction

    function automatic tex_req_t pixel_item(input int x, input int y);
        tex_req_t r;
        r = noise_req();
        r.cmd     = CMD_PIXEL;
        r.pixel_x = 16'(x);
        r.pixel_y = 16'(y);
        return r;
    endfunction

    function automatic tex_req_t uv_item(input t_cmd c, input int u, input int v);
        tex_req_t r;
        r = noise_req();
        r.cmd     = c;
        r.coord_u = 18'(u);
        r.coord_v = 18'(v);
        return r;
    endfunction

    // Mostly coordinates near the texture, some anywhere in range
    function automatic tex_req_t random_req();
        tex_req_t r;
        r = noise_req();
        if (r.cmd == CMD_WRITE && tex_w * tex_h > 0 && $urandom_range(0, 1) == 1)
            r.texel_index = 16'($urandom_range(0, tex_w * tex_h - 1));
        if ($urandom_range(0, 9) < 7) begin
            r.pixel_x = 16'($urandom_range(0, tex_w + 3) - 2);
            r.pixel_y = 16'($urandom_range(0, tex_h + 3) - 2);
            r.coord_u = 18'($urandom_range(0, 73728) - 4096);
            r.coord_v = 18'($urandom_range(0, 73728) - 4096);
        end
        if ($urandom_range(0, 7) == 0)
            r.coord_u = 18'sd65536;
        if ($urandom_range(0, 7) == 0)
            r.coord_v = 18'sd65536;
        return r;
    endfunction

    // Present one item, idling a cycle at a time at random first, until it is taken
    task automatic send(input tex_req_t r);
        while (gaps_on && $urandom_range(0, 99) < 28) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        cmd         <= r.cmd;
        texel_index <= r.texel_index;
        byte_red    <= r.texel[7:0];
        byte_green  <= r.texel[15:8];
        byte_blue   <= r.texel[23:16];
        byte_alpha  <= r.texel[31:24];
        pixel_x     <= r.pixel_x;
        pixel_y     <= r.pixel_y;
        coord_u     <= r.coord_u;
        coord_v     <= r.coord_v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Stop sending and let every outstanding result come back
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_texture(input logic [8:0] w, input logic [8:0] h,
                               input logic [8:0] ch);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TEX_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        cfg_index <= CFG_TEX_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        cfg_index <= CFG_CHANNEL_COUNT;
        cfg_data  <= ch;
        @(posedge clk);
        cfg_index <= CFG_SPARE;
        cfg_data  <= 9'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
        tex_w = (w > 9'd256) ? 256 : int'(w);
        tex_h = (h > 9'd256) ? 256 : int'(h);
    endtask

    // Every texel a read can reach gets written before any read; the store
    // keeps texels from earlier phases, so only addresses not yet reached are filled
    task automatic fill_texture();
        for (int unsigned i = filled; i < tex_w * tex_h; i++)
            send(write_item(16'(i), $urandom));
        if (tex_w * tex_h > filled)
            filled = tex_w * tex_h;
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values give an empty texture: reads return white
        send(pixel_item(0, 0));
        send(uv_item(CMD_NEAREST, 0, 0));
        send(uv_item(CMD_BILINEAR, 65536, 65536));
        send(write_item(16'd3, $urandom));
        drain();

        // directed: 4x3 RGBA texture, field extremes and clamping
        set_texture(9'd4, 9'd3, 9'd4);
        fill_texture();
        send(write_item(16'd0, 32'h0000_0000));
        send(write_item(16'd11, 32'hFFFF_FFFF));
        send(write_item(16'd5, 32'h807F_01FE));
        send(pixel_item(-32768, -32768));
        send(pixel_item(32767, 32767));
        send(pixel_item(1, 1));
        send(pixel_item(-1, 2));
        send(pixel_item(4, 0));
        send(uv_item(CMD_NEAREST, -131072, -131072));
        send(uv_item(CMD_NEAREST, 131071, 131071));
        send(uv_item(CMD_NEAREST, 65535, 32768));
        send(uv_item(CMD_NEAREST, 0, 65536));
        send(uv_item(CMD_BILINEAR, 32768, 32768));
        send(uv_item(CMD_BILINEAR, 65536, 65536));
        send(uv_item(CMD_BILINEAR, -131072, 131071));
        send(uv_item(CMD_BILINEAR, 21845, 43691));
        send(uv_item(CMD_BILINEAR, 65535, 1));
        // writes outside the texture but inside the store
        send(write_item(16'hFFFF, $urandom));
        send(write_item(16'h8000, $urandom));
        drain();

        // random phases: edge sizes first, then random small textures
        for (int p = 0; p < PHASES; p++) begin
            gaps_on = (p != 1) && (p != 8);
            case (p)
                0:       set_texture(9'd1, 9'd1, 9'd1);
                1:       set_texture(9'd256, 9'd1, 9'd3);
                2:       set_texture(9'd1, 9'd256, 9'd2);
                3:       set_texture(9'd511, 9'd1, 9'h1FF);
                4:       set_texture(9'd5, 9'd5, 9'd0);
                5:       set_texture(9'd0, 9'd9, 9'd4);
                6:       set_texture(9'd9, 9'd0, 9'd4);
                default: set_texture(9'($urandom_range(2, 16)), 9'($urandom_range(2, 16)),
                                     9'($urandom_range(1, 7)));
            endcase
            fill_texture();
            for (int n = 0; n < PHASE_ITEMS; n++)
                send(random_req());
            drain();
        end

        if (err_count == 0 && pending == 0)
            $display("bilinear_texture_sampler_core_tb: clean");
        else
            $display("bilinear_texture_sampler_core_tb: errors");
        $finish;
    end

endmodule
